FILE: hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication check.
`define ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication check.
`define ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/cbrm_pkg.sv
`timescale 1ns / 1ps
package cbrm_pkg;

  localparam int OP_W  = 4;
  localparam int IDX_W = 4;
  localparam int CNT_W = 5;

  localparam logic [OP_W-1:0] OP_INIT    = 4'd0;
  localparam logic [OP_W-1:0] OP_TAKE    = 4'd1;
  localparam logic [OP_W-1:0] OP_RETURN  = 4'd2;
  localparam logic [OP_W-1:0] OP_ENQ     = 4'd3;
  localparam logic [OP_W-1:0] OP_DEQ     = 4'd4;
  localparam logic [OP_W-1:0] OP_VACANT  = 4'd5;
  localparam logic [OP_W-1:0] OP_CAPDONE = 4'd6;
  localparam logic [OP_W-1:0] OP_MODE    = 4'd7;
  localparam logic [OP_W-1:0] OP_POP     = 4'd8;

endpackage

FILE: hdl/cbrm_link_mem.sv
`timescale 1ns / 1ps
module cbrm_link_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int DW    = 5
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/capture_buffer_ring_manager_unit.sv
`timescale 1ns / 1ps
// Capture buffer descriptor ring manager.
// Command channel: an item (op, container, new_mode) is taken at a clock edge
// with start high and busy low. Each item gives one result: done pulses for
// one cycle with found and result_container (zero when nothing is returned).
// The receiver cannot stall; results are never held.
// Config: cfg_wr_en/cfg_wr_data write container_count; write only while idle.
// States after the item is taken: return, change mode, get vacant and empty
// cases end in EXEC; take free in EXEC, EVAL; enqueue in EXEC, WR2; dequeue
// and pop in EXEC, EVAL, WR2 (EXEC alone for the last element); capture done
// in EXEC, EVAL, plus EVAL2, EVAL3 on ring overwrite; init in EXEC, SWEEP.
// The link table has one synchronous read port, so items go one at a time.
// Reset: pointers go null, ring mode is set, and a clearing pass writes null
// to every link in turn with busy high; no result is made.
module capture_buffer_ring_manager_unit #(
  parameter int MAX_CONTAINERS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [cbrm_pkg::OP_W-1:0]  op,
  input  logic [cbrm_pkg::IDX_W-1:0] container,
  input  logic                       new_mode,
  output logic                       busy,
  output logic                       done,
  output logic                       found,
  output logic [cbrm_pkg::IDX_W-1:0] result_container,
  input  logic                       cfg_wr_en,
  input  logic [cbrm_pkg::CNT_W-1:0] cfg_wr_data
);
  import cbrm_pkg::*;

  localparam int LW = $clog2(MAX_CONTAINERS + 1);
  localparam int IW = (MAX_CONTAINERS > 1) ? $clog2(MAX_CONTAINERS) : 1;
  localparam int CW = (LW > CNT_W) ? LW : CNT_W;
  localparam int XW = LW + IDX_W;
  localparam logic [LW-1:0] NULL_LINK = LW'(MAX_CONTAINERS);
  localparam logic [CW-1:0] MAX_W     = CW'(MAX_CONTAINERS);
  localparam logic [IW-1:0] LAST_IDX  = IW'(MAX_CONTAINERS - 1);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_EXEC  = 7'b0000010,
    ST_EVAL  = 7'b0000100,
    ST_EVAL2 = 7'b0001000,
    ST_EVAL3 = 7'b0010000,
    ST_WR2   = 7'b0100000,
    ST_SWEEP = 7'b1000000
  } state_t;

  state_t state, state_next;

  logic [OP_W-1:0]  op_q;
  logic [LW-1:0]    c_q;
  logic             c_ok_q;
  logic             want_ring_q;
  logic [LW-1:0]    free_head, free_head_next;
  logic [LW-1:0]    queue_top, queue_top_next;
  logic [LW-1:0]    queue_tail, queue_tail_next;
  logic [LW-1:0]    fill_next, fill_next_next;
  logic             ring_mode, ring_mode_next;
  logic [CNT_W-1:0] container_count;
  logic [LW-1:0]    ret, ret_next;
  logic [IW-1:0]    sweep_idx, sweep_idx_next;
  logic [LW-1:0]    sweep_n, sweep_n_next;
  logic             sweep_report, sweep_report_next;
  logic             rd_null;

  logic [CW-1:0] c_wide;
  logic [CW-1:0] cnt_wide;
  logic [LW-1:0] n_calc;
  logic [LW-1:0] idx_p1;
  logic [LW-1:0] link_rd;
  logic [LW-1:0] mem_rdata;
  logic          wr_en;
  logic [LW-1:0] wr_ptr;
  logic [LW-1:0] wr_data;
  logic [LW-1:0] rd_ptr;
  logic          fin;
  logic [LW-1:0] fin_ret;
  logic [XW-1:0] fin_ret_x;
  logic          pop_ok;

  function automatic logic is_idx(logic [LW-1:0] p);
    return p < NULL_LINK;
  endfunction

  assign busy     = (state != ST_IDLE);
  assign c_wide   = CW'(container);
  assign cnt_wide = CW'(container_count);
  assign n_calc   = (cnt_wide > MAX_W) ? NULL_LINK : cnt_wide[LW-1:0];
  assign idx_p1   = LW'(sweep_idx) + LW'(1);
  assign link_rd  = rd_null ? NULL_LINK : mem_rdata;
  assign fin_ret_x = XW'(fin_ret);
  assign pop_ok   = (queue_top != NULL_LINK) &&
                    ((op_q == OP_POP) || (queue_top != fill_next));

  cbrm_link_mem #(
    .DEPTH (MAX_CONTAINERS),
    .AW    (IW),
    .DW    (LW)
  ) u_link_mem (
    .clk   (clk),
    .we    (wr_en && is_idx(wr_ptr)),
    .waddr (wr_ptr[IW-1:0]),
    .wdata (wr_data),
    .raddr (rd_ptr[IW-1:0]),
    .rdata (mem_rdata)
  );

  always_comb begin
    state_next        = state;
    free_head_next    = free_head;
    queue_top_next    = queue_top;
    queue_tail_next   = queue_tail;
    fill_next_next    = fill_next;
    ring_mode_next    = ring_mode;
    ret_next          = ret;
    sweep_idx_next    = sweep_idx;
    sweep_n_next      = sweep_n;
    sweep_report_next = sweep_report;
    wr_en             = 1'b0;
    wr_ptr            = NULL_LINK;
    wr_data           = NULL_LINK;
    rd_ptr            = NULL_LINK;
    fin               = 1'b0;
    fin_ret           = NULL_LINK;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_next = ST_IDLE;
        case (op_q)
          OP_INIT: begin
            free_head_next    = (n_calc != '0) ? '0 : NULL_LINK;
            queue_top_next    = NULL_LINK;
            queue_tail_next   = NULL_LINK;
            fill_next_next    = NULL_LINK;
            sweep_n_next      = n_calc;
            sweep_idx_next    = '0;
            sweep_report_next = 1'b1;
            state_next        = ST_SWEEP;
          end
          OP_TAKE: begin
            if (is_idx(free_head)) begin
              rd_ptr     = free_head;
              ret_next   = free_head;
              state_next = ST_EVAL;
            end else begin
              fin = 1'b1;
            end
          end
          OP_RETURN: begin
            if (c_ok_q) begin
              wr_en          = 1'b1;
              wr_ptr         = c_q;
              wr_data        = free_head;
              free_head_next = c_q;
            end
            fin = 1'b1;
          end
          OP_ENQ: begin
            if (c_ok_q) begin
              if (queue_top != NULL_LINK) begin
                wr_en           = 1'b1;
                wr_ptr          = queue_tail;
                wr_data         = c_q;
                queue_tail_next = c_q;
              end else begin
                queue_top_next  = c_q;
                queue_tail_next = c_q;
              end
              if (fill_next == NULL_LINK) begin
                fill_next_next = c_q;
              end
              state_next = ST_WR2;
            end else begin
              fin = 1'b1;
            end
          end
          OP_DEQ, OP_POP: begin
            if (pop_ok) begin
              ret_next = queue_top;
              if (queue_top == queue_tail) begin
                queue_top_next  = NULL_LINK;
                queue_tail_next = NULL_LINK;
                fill_next_next  = NULL_LINK;
                wr_en           = 1'b1;
                wr_ptr          = queue_top;
                wr_data         = NULL_LINK;
                fin             = 1'b1;
                fin_ret         = queue_top;
              end else begin
                rd_ptr     = queue_top;
                state_next = ST_EVAL;
              end
            end else begin
              fin = 1'b1;
            end
          end
          OP_VACANT: begin
            fin     = 1'b1;
            fin_ret = fill_next;
          end
          OP_CAPDONE: begin
            if (fill_next != NULL_LINK) begin
              rd_ptr     = fill_next;
              state_next = ST_EVAL;
            end else begin
              fin = 1'b1;
            end
          end
          OP_MODE: begin
            if (ring_mode != want_ring_q) begin
              if (queue_tail != NULL_LINK) begin
                wr_en   = 1'b1;
                wr_ptr  = queue_tail;
                wr_data = want_ring_q ? queue_top : NULL_LINK;
              end
              fill_next_next = queue_top;
              ring_mode_next = want_ring_q;
            end
            fin = 1'b1;
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end
      ST_EVAL: begin
        state_next = ST_IDLE;
        case (op_q)
          OP_TAKE: begin
            free_head_next = link_rd;
            wr_en          = 1'b1;
            wr_ptr         = ret;
            wr_data        = NULL_LINK;
            fin            = 1'b1;
            fin_ret        = ret;
          end
          OP_DEQ, OP_POP: begin
            queue_top_next = link_rd;
            if (ring_mode) begin
              wr_en   = 1'b1;
              wr_ptr  = queue_tail;
              wr_data = link_rd;
            end
            state_next = ST_WR2;
          end
          OP_CAPDONE: begin
            fill_next_next = link_rd;
            if (link_rd == queue_top) begin
              rd_ptr     = queue_top;
              state_next = ST_EVAL2;
            end else begin
              fin = 1'b1;
            end
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end
      ST_EVAL2: begin
        queue_top_next = link_rd;
        rd_ptr         = queue_tail;
        state_next     = ST_EVAL3;
      end
      ST_EVAL3: begin
        queue_tail_next = link_rd;
        fin             = 1'b1;
        state_next      = ST_IDLE;
      end
      ST_WR2: begin
        wr_en = 1'b1;
        fin   = 1'b1;
        if (op_q == OP_ENQ) begin
          wr_ptr  = c_q;
          wr_data = ring_mode ? queue_top : NULL_LINK;
        end else begin
          wr_ptr  = ret;
          wr_data = NULL_LINK;
          fin_ret = ret;
        end
        state_next = ST_IDLE;
      end
      ST_SWEEP: begin
        wr_en   = 1'b1;
        wr_ptr  = LW'(sweep_idx);
        wr_data = (idx_p1 < sweep_n) ? idx_p1 : NULL_LINK;
        if (sweep_idx == LAST_IDX) begin
          fin        = sweep_report;
          state_next = ST_IDLE;
        end else begin
          sweep_idx_next = sweep_idx + IW'(1);
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_SWEEP;
      free_head       <= NULL_LINK;
      queue_top       <= NULL_LINK;
      queue_tail      <= NULL_LINK;
      fill_next       <= NULL_LINK;
      ring_mode       <= 1'b1;
      container_count <= '0;
      sweep_idx       <= '0;
      sweep_n         <= '0;
      sweep_report    <= 1'b0;
      done            <= 1'b0;
      found           <= 1'b0;
    end else begin
      state        <= state_next;
      free_head    <= free_head_next;
      queue_top    <= queue_top_next;
      queue_tail   <= queue_tail_next;
      fill_next    <= fill_next_next;
      ring_mode    <= ring_mode_next;
      sweep_idx    <= sweep_idx_next;
      sweep_n      <= sweep_n_next;
      sweep_report <= sweep_report_next;
      done         <= fin;
      found        <= fin && is_idx(fin_ret);
      if (cfg_wr_en) begin
        container_count <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    ret     <= ret_next;
    rd_null <= !is_idx(rd_ptr);
    result_container <= (fin && is_idx(fin_ret)) ? fin_ret_x[IDX_W-1:0] : '0;
    if (start && !busy) begin
      op_q        <= op;
      c_q         <= c_wide[LW-1:0];
      c_ok_q      <= c_wide < MAX_W;
      want_ring_q <= ~new_mode;
    end
  end

endmodule

FILE: hdl/cbrm_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cbrm_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       start,
  input logic [cbrm_pkg::OP_W-1:0]  op,
  input logic                       busy,
  input logic                       done,
  input logic                       found,
  input logic [cbrm_pkg::IDX_W-1:0] result_container
);
  import cbrm_pkg::*;

  // every item, init included, raises busy once accepted
  `ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy, "accepted item did not raise busy")
  `ASSERT_IMPL(a_done_after_busy, clk, rst, done, $past(busy), "result without work")
  `ASSERT_IMPL(a_found_done, clk, rst, found, done, "found outside a result")
  `ASSERT_IMPL(a_empty_zero, clk, rst, done && !found, result_container == '0, "empty result not zero")
  `ASSERT_NEXT(a_init_no_result, clk, rst, start && !busy && op == OP_INIT, !done, "init result too early")

endmodule

bind capture_buffer_ring_manager_unit cbrm_checker u_cbrm_checker (.*);

FILE: dv/tb.sv
`timescale 1ns / 1ps
module tb;
  import cbrm_pkg::*;

  localparam int MAX_DESC = 16;
  localparam logic [4:0] NIL_LINK = 5'(MAX_DESC);
  localparam logic [OP_W-1:0] OP_SPARE_FIRST = OP_POP + 1'b1;
  localparam logic [OP_W-1:0] OP_SPARE_LAST = '1;
  localparam int N_DIRECTED = 28;
  localparam int N_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 86;

  typedef struct packed {
    logic found;
    logic [IDX_W-1:0] idx;
  } reply_t;

  typedef struct packed {
    logic is_cfg;
    logic [OP_W-1:0] op;
    logic [IDX_W-1:0] container;
    logic new_mode;
    logic [CNT_W-1:0] count;
    logic typed;
    logic found;
    logic [IDX_W-1:0] idx;
  } row_t;

  localparam row_t DIRECTED [0:N_DIRECTED-1] = '{
    '{1'b0, OP_TAKE,      4'd0,  1'b0, 5'd0,  1'b1, 1'b0, 4'd0},
    '{1'b0, OP_VACANT,    4'd0,  1'b0, 5'd0,  1'b1, 1'b0, 4'd0},
    '{1'b0, OP_DEQ,       4'd0,  1'b0, 5'd0,  1'b1, 1'b0, 4'd0},
    '{1'b0, OP_POP,       4'd0,  1'b0, 5'd0,  1'b1, 1'b0, 4'd0},
    '{1'b0, OP_SPARE_LAST, 4'd15, 1'b1, 5'd0, 1'b1, 1'b0, 4'd0},
    '{1'b1, OP_INIT,      4'd0,  1'b0, 5'd16, 1'b0, 1'b0, 4'd0},
    '{1'b0, OP_INIT,      4'd0,  1'b0, 5'd0,  1'b1, 1'b0, 4'd0},
    '{1'b0, OP_TAKE,      4'd0,  1'b0, 5'd0,  1'b1, 1'b1, 4'd0},
    '{1'b0, OP_TAKE,      4'd0,  1'b0, 5'd0,  1'b1, 1'b1, 4'd1},
    '{1'b0, OP_ENQ,       4'd0,  1'b0, 5'd0,  1'b1, 1'b0, 4'd0},
    '{1'b0, OP_ENQ,       4'd1,  1'b0, 5'd0,  1'b1, 1'b0, 4'd0},
    '{1'b0, OP_ENQ,       4'd15, 1'b1, 5'd0,  1'b1, 1'b0, 4'd0},
    '{1'b0, OP_VACANT,    4'd0,  1'b0, 5'd0,  1'b0, 1'b0, 4'd0},
    '{1'b0, OP_CAPDONE,   4'd0,  1'b0, 5'd0,  1'b1, 1'b0, 4'd0},
    '{1'b0, OP_DEQ,       4'd0,  1'b0, 5'd0,  1'b0, 1'b0, 4'd0},
    '{1'b0, OP_MODE,      4'd0,  1'b1, 5'd0,  1'b0, 1'b0, 4'd0},
    '{1'b0, OP_MODE,      4'd0,  1'b1, 5'd0,  1'b0, 1'b0, 4'd0},
    '{1'b0, OP_CAPDONE,   4'd0,  1'b0, 5'd0,  1'b1, 1'b0, 4'd0},
    '{1'b0, OP_POP,       4'd0,  1'b0, 5'd0,  1'b0, 1'b0, 4'd0},
    '{1'b0, OP_RETURN,    4'd15, 1'b0, 5'd0,  1'b1, 1'b0, 4'd0},
    '{1'b0, OP_MODE,      4'd0,  1'b0, 5'd0,  1'b0, 1'b0, 4'd0},
    '{1'b0, OP_VACANT,    4'd0,  1'b0, 5'd0,  1'b0, 1'b0, 4'd0},
    '{1'b1, OP_INIT,      4'd0,  1'b0, 5'd31, 1'b0, 1'b0, 4'd0},
    '{1'b0, OP_INIT,      4'd0,  1'b0, 5'd0,  1'b1, 1'b0, 4'd0},
    '{1'b0, OP_TAKE,      4'd0,  1'b0, 5'd0,  1'b1, 1'b1, 4'd0},
    '{1'b1, OP_INIT,      4'd0,  1'b0, 5'd0,  1'b0, 1'b0, 4'd0},
    '{1'b0, OP_INIT,      4'd0,  1'b0, 5'd0,  1'b1, 1'b0, 4'd0},
    '{1'b0, OP_TAKE,      4'd0,  1'b0, 5'd0,  1'b1, 1'b0, 4'd0}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [OP_W-1:0] op = OP_INIT;
  logic [IDX_W-1:0] container = '0;
  logic new_mode = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [CNT_W-1:0] cfg_wr_data = '0;
  logic busy;
  logic done;
  logic found;
  logic [IDX_W-1:0] result_container;

  // shadow of the descriptor pool
  logic [4:0] links [MAX_DESC];
  logic [4:0] free_head, q_top, q_tail, fill_next, fill_cur;
  logic ring;
  logic [CNT_W-1:0] desc_count;

  reply_t returns_due [$];
  int n_errors = 0;
  int n_items = 0;
  int n_checked = 0;
  int n_handed = 0;
  int n_cfg = 0;

  capture_buffer_ring_manager_unit #(.MAX_CONTAINERS(MAX_DESC)) DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .op(op),
    .container(container),
    .new_mode(new_mode),
    .busy(busy),
    .done(done),
    .found(found),
    .result_container(result_container),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic [4:0] link_of(logic [4:0] i);
    return (i < NIL_LINK) ? links[i[3:0]] : NIL_LINK;
  endfunction

  function automatic void set_link(logic [4:0] i, logic [4:0] v);
    if (i < NIL_LINK) links[i[3:0]] = v;
  endfunction

  function automatic logic [4:0] pop_top();
    logic [4:0] r;
    r = q_top;
    if (q_top == q_tail) begin
      q_top = NIL_LINK;
      q_tail = NIL_LINK;
      fill_next = NIL_LINK;
    end else begin
      q_top = link_of(q_top);
      if (ring) set_link(q_tail, q_top);
    end
    set_link(r, NIL_LINK);
    return r;
  endfunction

  function automatic void rebuild_chain();
    int n;
    n = (desc_count > MAX_DESC) ? MAX_DESC : int'(desc_count);
    for (int i = 0; i < MAX_DESC; i++) links[i] = NIL_LINK;
    for (int i = 1; i < n; i++) links[i-1] = 5'(i);
    free_head = (n != 0) ? 5'd0 : NIL_LINK;
    q_top = NIL_LINK;
    q_tail = NIL_LINK;
    fill_next = NIL_LINK;
    fill_cur = NIL_LINK;
  endfunction

  function automatic reply_t apply_descriptor_op(logic [OP_W-1:0] code,
                                                 logic [IDX_W-1:0] c, logic md);
    logic [4:0] ret;
    logic [4:0] cx;
    reply_t r;
    ret = NIL_LINK;
    cx = {1'b0, c};
    case (code)
      OP_INIT: rebuild_chain();
      OP_TAKE: begin
        ret = free_head;
        if (ret != NIL_LINK) begin
          free_head = link_of(ret);
          set_link(ret, NIL_LINK);
        end
      end
      OP_RETURN: begin
        links[c] = free_head;
        free_head = cx;
      end
      OP_ENQ: begin
        if (q_top != NIL_LINK) begin
          set_link(q_tail, cx);
          q_tail = cx;
        end else begin
          q_top = cx;
          q_tail = cx;
        end
        if (fill_next == NIL_LINK) fill_next = cx;
        links[c] = ring ? q_top : NIL_LINK;
      end
      OP_DEQ: if (q_top != NIL_LINK && q_top != fill_next) ret = pop_top();
      OP_VACANT: begin
        fill_cur = fill_next;
        ret = fill_next;
      end
      OP_CAPDONE: begin
        fill_cur = NIL_LINK;
        if (fill_next != NIL_LINK) begin
          fill_next = link_of(fill_next);
          // ring overwrite of the oldest frame
          if (fill_next == q_top) begin
            q_top = link_of(q_top);
            q_tail = link_of(q_tail);
          end
        end
      end
      OP_MODE: if (ring != !md) begin
        if (q_tail != NIL_LINK) set_link(q_tail, !md ? q_top : NIL_LINK);
        fill_next = q_top;
        ring = !md;
      end
      OP_POP: if (q_top != NIL_LINK) ret = pop_top();
      default: ;
    endcase
    r.found = (ret != NIL_LINK);
    r.idx = r.found ? ret[3:0] : '0;
    return r;
  endfunction

  task automatic send_cmd(logic [OP_W-1:0] code, logic [IDX_W-1:0] c, logic md,
                          logic typed, reply_t typed_reply);
    reply_t r;
    start <= 1'b1;
    op <= code;
    container <= c;
    new_mode <= md;
    do @(posedge clk); while (busy);
    r = apply_descriptor_op(code, c, md);
    returns_due.push_back(typed ? typed_reply : r);
    n_items++;
  endtask

  task automatic idle_cycles(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (returns_due.size() != 0 || busy);
  endtask

  task automatic set_count(logic [CNT_W-1:0] v);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    desc_count = v;
    n_cfg++;
  endtask

  always @(posedge clk) begin
    reply_t e;
    if (!rst && done) begin
      if (returns_due.size() == 0) begin
        $error("result_container: unexpected item found=%0d idx=%0d",
               found, result_container);
        n_errors++;
      end else begin
        e = returns_due.pop_front();
        n_checked++;
        if (found) n_handed++;
        if (found !== e.found) begin
          $error("found: expected %0d, got %0d", e.found, found);
          n_errors++;
        end
        if (result_container !== e.idx) begin
          $error("result_container: expected %0d, got %0d", e.idx, result_container);
          n_errors++;
        end
      end
    end
  end

  initial begin
    int idle_pct [4];
    logic [CNT_W-1:0] counts [N_PHASES];
    int gap;
    int pick;
    int span;
    logic [OP_W-1:0] code;
    logic [IDX_W-1:0] c;
    row_t row;

    idle_pct = '{0, 82, 0, 19};
    counts = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd7, 5'd16, 5'd0, 5'd2};
    counts[6] = 5'($urandom_range(0, 31));

    desc_count = '0;
    rebuild_chain();
    ring = 1'b1;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_DIRECTED; i++) begin
      row = DIRECTED[i];
      if (row.is_cfg) set_count(row.count);
      else send_cmd(row.op, row.container, row.new_mode, row.typed,
                    '{row.found, row.idx});
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      set_count(counts[ph]);
      send_cmd(OP_INIT, 4'($urandom), 1'($urandom), 1'b0, '0);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        gap = 0;
        while (gap < 60 && $urandom_range(0, 99) < idle_pct[ph % 4]) gap++;
        if ($urandom_range(0, 59) == 0) drain();
        else if (gap != 0) idle_cycles(gap);

        pick = $urandom_range(0, 99);
        if (pick < 2) code = OP_INIT;
        else if (pick < 16) code = OP_TAKE;
        else if (pick < 28) code = OP_RETURN;
        else if (pick < 45) code = OP_ENQ;
        else if (pick < 57) code = OP_DEQ;
        else if (pick < 69) code = OP_VACANT;
        else if (pick < 83) code = OP_CAPDONE;
        else if (pick < 90) code = OP_MODE;
        else if (pick < 97) code = OP_POP;
        else code = 4'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));

        // mostly descriptors inside the configured pool
        span = (desc_count > MAX_DESC) ? MAX_DESC : int'(desc_count);
        if (span != 0 && $urandom_range(0, 3) != 0) c = 4'($urandom_range(0, span - 1));
        else c = 4'($urandom);
        send_cmd(code, c, 1'($urandom), 1'b0, '0);
      end
    end

    drain();
    idle_cycles(2 * MAX_DESC + 8);

    $display("Ran %0d commands over %0d pool sizes; %0d replies checked, %0d with a descriptor",
             n_items, n_cfg, n_checked, n_handed);
    if (n_errors == 0 && returns_due.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/cbrm_pkg.sv
hdl/cbrm_link_mem.sv
hdl/capture_buffer_ring_manager_unit.sv
hdl/cbrm_checker.sv
dv/tb.sv
